// File: sv/ptw_pkg.sv
// ptw_pkg: shared types and constants for the four-level page-table walker
// used by ptw_ctrl, ptw_datapath and four_level_page_table_walker
package ptw_pkg;

    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int STORE_WORDS       = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int WORD_W            = $clog2(STORE_WORDS);
    localparam int PA_W              = 52;
    localparam int VA_W              = 48;
    localparam int DATA_W            = 64;
    localparam int IDX_W             = 9;
    localparam int LEVEL_W           = 2;
    localparam logic [PA_W-1:0] STORE_BYTES = PA_W'(STORE_WORDS * 8);

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_LARGE_BIT   = 7;

    localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 2'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_PD   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_PT   = 2'd0;

    // configuration register indexes
    localparam logic REG_ROOT = 1'b0;
    localparam logic REG_BASE = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_READ      = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_UNMAP     = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_RANGE  = 2'd2
    } status_code_t;

    localparam logic [1:0] KIND_4K = 2'd0;
    localparam logic [1:0] KIND_2M = 2'd1;
    localparam logic [1:0] KIND_1G = 2'd2;

    typedef enum logic [2:0] {
        VAL_ZERO,
        VAL_READ,
        VAL_1G,
        VAL_2M,
        VAL_4K
    } val_sel_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_CHECK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic         capture;
        logic         mem_rd;
        logic         mem_wr;
        logic         wr_zero;
        logic         level_load;
        logic         level_dec;
        logic         from_entry;
        logic         finish;
        status_code_t fin_status;
        val_sel_t     val_sel;
    } ptw_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_code_t          cmd;
        logic [LEVEL_W-1:0] level;
        logic               in_range;
        logic               present;
        logic               huge;
    } ptw_stat_t;

endpackage

// File: sv/four_level_page_table_walker.sv
// four_level_page_table_walker: top level with configuration registers and result register
// depends on ptw_pkg, ptw_ctrl and ptw_datapath
//
//  channel  direction  handshake           payload
//  in       to block   in_valid/in_stall   command, address, write_data
//  out      from block out_valid/out_stall result_value, status, page_kind
//  config   to block   config_write        config_index, config_data
//
// one item at a time, beat to beat: a table write, read or walk is through before the
// next beat is taken; a walk reads one table level at a time, set by the single port of
// the table store with the registered read in each level's path
// reset clears control and configuration; the table store holds no reset value
// a finished result waits in the output register; the next beat is taken meanwhile
// and its own result is held back until out_stall lets the register go
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [VA_W-1:0]   address,
    input  logic [DATA_W-1:0] write_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] result_value,
    output logic [1:0]        status,
    output logic [1:0]        page_kind,
    input  logic              config_write,
    input  logic              config_index,
    input  logic [PA_W-1:0]   config_data
);

    logic [PA_W-1:0]   root_reg;
    logic [PA_W-1:0]   base_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] value_reg;
    logic [1:0]        status_reg;
    logic [1:0]        kind_reg;

    ptw_cmd_t          ctl;
    ptw_stat_t         stat;
    logic              busy;
    logic              can_finish;
    logic [DATA_W-1:0] res_value;
    logic [1:0]        res_status;
    logic [1:0]        res_kind;

    assign can_finish = !out_valid_reg || !out_stall;

    ptw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .can_finish (can_finish),
        .stat       (stat),
        .ctl        (ctl),
        .busy       (busy)
    );

    ptw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .command         (command),
        .address         (address),
        .write_data      (write_data),
        .root_table_addr (root_reg),
        .store_base_addr (base_reg),
        .stat            (stat),
        .res_value       (res_value),
        .res_status      (res_status),
        .res_kind        (res_kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (config_write)
            begin
                unique case (config_index)
                    REG_ROOT: root_reg <= config_data;
                    REG_BASE: base_reg <= config_data;
                    default:  root_reg <= root_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
            kind_reg   <= res_kind;
        end
    end

    assign in_stall     = busy;
    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign page_kind    = kind_reg;

endmodule

// File: sv/ptw_datapath.sv
// ptw_datapath: table store, request registers, address locate and result forming
// depends on ptw_pkg; steered by ptw_ctrl
module ptw_datapath
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptw_cmd_t          ctl,
    input  logic [1:0]        command,
    input  logic [VA_W-1:0]   address,
    input  logic [DATA_W-1:0] write_data,
    input  logic [PA_W-1:0]   root_table_addr,
    input  logic [PA_W-1:0]   store_base_addr,
    output ptw_stat_t         stat,
    output logic [DATA_W-1:0] res_value,
    output logic [1:0]        res_status,
    output logic [1:0]        res_kind
);

    logic [1:0]         cmd_reg;
    logic [VA_W-1:0]    addr_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [WORD_W-1:0]  word_reg;
    logic [DATA_W-1:0]  mem_q_reg;

    logic [DATA_W-1:0]  table_store [STORE_WORDS];

    logic [IDX_W-1:0]   idx_next;
    logic [PA_W-1:0]    ea;
    logic [PA_W:0]      diff;
    logic [WORD_W-1:0]  loc_word;
    logic [WORD_W-1:0]  mem_addr;
    logic [DATA_W-1:0]  mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_PT;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        level_next = level_reg;
        if (ctl.level_load)
        begin
            level_next = LEVEL_PML4;
        end
        else if (ctl.level_dec)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
            data_reg <= write_data;
        end
        if (ctl.mem_rd)
        begin
            word_reg <= loc_word;
        end
    end

    // next-level index
    always_comb
    begin
        unique case (level_reg)
            LEVEL_PML4: idx_next = addr_reg[38:30];
            LEVEL_PDPT: idx_next = addr_reg[29:21];
            default:    idx_next = addr_reg[20:12];
        endcase
    end

    always_comb
    begin
        if (ctl.from_entry)
        begin
            ea = {mem_q_reg[51:12], idx_next, 3'b000};
        end
        else if (cmd_reg == CMD_WRITE || cmd_reg == CMD_READ)
        begin
            ea = {{(PA_W-VA_W){1'b0}}, addr_reg};
        end
        else
        begin
            ea = {root_table_addr[51:12], addr_reg[47:39], 3'b000};
        end
    end

    assign diff     = {1'b0, ea} - {1'b0, store_base_addr};
    assign loc_word = diff[WORD_W+2:3];

    assign mem_addr  = ctl.wr_zero ? word_reg : loc_word;
    assign mem_wdata = ctl.wr_zero ? '0 : data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mem_wr)
        begin
            table_store[mem_addr] <= mem_wdata;
        end
        if (ctl.mem_rd)
        begin
            mem_q_reg <= table_store[mem_addr];
        end
    end

    assign stat.cmd      = cmd_code_t'(cmd_reg);
    assign stat.level    = level_reg;
    assign stat.in_range = !diff[PA_W] && (diff[PA_W-1:0] < STORE_BYTES);
    assign stat.present  = mem_q_reg[ENTRY_PRESENT_BIT];
    assign stat.huge     = mem_q_reg[ENTRY_LARGE_BIT];

    always_comb
    begin
        res_kind = KIND_4K;
        unique case (ctl.val_sel)
            VAL_READ: res_value = mem_q_reg;
            VAL_1G:
            begin
                res_value = {12'b0, mem_q_reg[51:30], addr_reg[29:0]};
                res_kind  = KIND_1G;
            end
            VAL_2M:
            begin
                res_value = {12'b0, mem_q_reg[51:21], addr_reg[20:0]};
                res_kind  = KIND_2M;
            end
            VAL_4K:   res_value = {12'b0, mem_q_reg[51:12], addr_reg[11:0]};
            default:  res_value = '0;
        endcase
    end

    assign res_status = ctl.fin_status;

endmodule

// File: sv/ptw_ctrl.sv
// ptw_ctrl: command sequencer for table access, walk and unmap
// depends on ptw_pkg; drives ptw_datapath
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      can_finish,
    input  ptw_stat_t stat,
    output ptw_cmd_t  ctl,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;
    logic   fin;
    logic   want_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.fin_status = ST_OK;
        ctl.val_sel    = VAL_ZERO;
        fin            = 1'b0;
        want_wr        = 1'b0;
        busy           = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (!stat.in_range)
                begin
                    fin            = 1'b1;
                    ctl.fin_status = ST_RANGE;
                end
                else if (stat.cmd == CMD_WRITE)
                begin
                    fin     = 1'b1;
                    want_wr = 1'b1;
                end
                else
                begin
                    ctl.mem_rd     = 1'b1;
                    ctl.level_load = (stat.cmd != CMD_READ);
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.from_entry = 1'b1;
                if (stat.cmd == CMD_READ)
                begin
                    fin         = 1'b1;
                    ctl.val_sel = VAL_READ;
                end
                else if (!stat.present)
                begin
                    fin            = 1'b1;
                    ctl.fin_status = ST_ABSENT;
                end
                else if (stat.cmd == CMD_TRANSLATE && stat.huge
                         && stat.level == LEVEL_PDPT)
                begin
                    fin         = 1'b1;
                    ctl.val_sel = VAL_1G;
                end
                else if (stat.cmd == CMD_TRANSLATE && stat.huge
                         && stat.level == LEVEL_PD)
                begin
                    fin         = 1'b1;
                    ctl.val_sel = VAL_2M;
                end
                else if (stat.level == LEVEL_PT)
                begin
                    fin = 1'b1;
                    if (stat.cmd == CMD_TRANSLATE)
                    begin
                        ctl.val_sel = VAL_4K;
                    end
                    else
                    begin
                        want_wr     = 1'b1;
                        ctl.wr_zero = 1'b1;
                    end
                end
                else if (!stat.in_range)
                begin
                    fin            = 1'b1;
                    ctl.fin_status = ST_RANGE;
                end
                else
                begin
                    ctl.mem_rd    = 1'b1;
                    ctl.level_dec = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold until the output register is free
        if (fin && can_finish)
        begin
            ctl.finish = 1'b1;
            ctl.mem_wr = want_wr;
            state_next = S_IDLE;
        end
    end

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for four_level_page_table_walker, with its own mirror of the
// table store that predicts every read, translation and unmap; depends on ptw_pkg and the RTL
// random walks build their tables on demand, so no unwritten table word is ever read
module tb;
    import ptw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FRAME_4K = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] FRAME_2M = 64'h000F_FFFF_FFE0_0000;
    localparam logic [63:0] FRAME_1G = 64'h000F_FFFF_C000_0000;
    localparam logic [63:0] OFF_4K   = 64'h0000_0000_0000_0FFF;
    localparam logic [63:0] OFF_2M   = 64'h0000_0000_001F_FFFF;
    localparam logic [63:0] OFF_1G   = 64'h0000_0000_3FFF_FFFF;
    localparam int STORE_SPAN = STORE_WORDS * 8;
    localparam int DRAIN = 16;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [1:0]        status;
        logic [1:0]        kind;
    } walk_result_t;

    class ptw_mirror;
        bit [DATA_W-1:0] words [STORE_WORDS];
        bit              filled [STORE_WORDS];
        logic [PA_W-1:0] root_reg;
        logic [PA_W-1:0] base_reg;
        int              gap_word;
        walk_result_t    pending_results [$];
        int mismatches;
        int n_4k, n_2m, n_1g, n_absent, n_range;

        function new();
            root_reg = '0;
            base_reg = '0;
            gap_word = -1;
            mismatches = 0;
            n_4k = 0;
            n_2m = 0;
            n_1g = 0;
            n_absent = 0;
            n_range = 0;
        endfunction

        function bit locate(logic [63:0] byte_addr, output int word);
            logic [63:0] off;
            word = 0;
            if (byte_addr < {12'd0, base_reg})
                return 1'b0;
            off = byte_addr - {12'd0, base_reg};
            if (off >= 64'(STORE_SPAN))
                return 1'b0;
            word = int'(off >> 3);
            return 1'b1;
        endfunction

        function status_code_t fetch(logic [63:0] tbl, logic [IDX_W-1:0] idx,
                                     output logic [63:0] entry, output int word);
            entry = '0;
            if (!locate((tbl & FRAME_4K) + 64'({idx, 3'b000}), word))
                return ST_RANGE;
            if (!filled[word] && gap_word < 0)
                gap_word = word;
            entry = words[word];
            return entry[ENTRY_PRESENT_BIT] ? ST_OK : ST_ABSENT;
        endfunction

        // gap_word ends up as the first unwritten word the command would read
        function walk_result_t walk(cmd_code_t cmd, logic [VA_W-1:0] va,
                                    logic [DATA_W-1:0] data, bit commit);
            walk_result_t r;
            status_code_t st;
            logic [63:0]  e;
            logic [63:0]  va64;
            int           w;
            r.value = '0;
            r.status = ST_OK;
            r.kind = KIND_4K;
            gap_word = -1;
            va64 = {16'd0, va};
            if (cmd == CMD_WRITE || cmd == CMD_READ)
            begin
                if (!locate(va64, w))
                    r.status = ST_RANGE;
                else if (cmd == CMD_WRITE)
                begin
                    if (commit)
                    begin
                        words[w] = data;
                        filled[w] = 1'b1;
                    end
                end
                else
                begin
                    if (!filled[w])
                        gap_word = w;
                    r.value = words[w];
                end
                return r;
            end
            st = fetch({12'd0, root_reg}, va[47:39], e, w);
            if (st == ST_OK)
                st = fetch(e, va[38:30], e, w);
            if (st == ST_OK && cmd == CMD_TRANSLATE && e[ENTRY_LARGE_BIT])
            begin
                r.value = (e & FRAME_1G) | (va64 & OFF_1G);
                r.kind = KIND_1G;
            end
            else
            begin
                if (st == ST_OK)
                    st = fetch(e, va[29:21], e, w);
                if (st == ST_OK && cmd == CMD_TRANSLATE && e[ENTRY_LARGE_BIT])
                begin
                    r.value = (e & FRAME_2M) | (va64 & OFF_2M);
                    r.kind = KIND_2M;
                end
                else
                begin
                    if (st == ST_OK)
                        st = fetch(e, va[20:12], e, w);
                    if (st == ST_OK)
                    begin
                        if (cmd == CMD_TRANSLATE)
                            r.value = (e & FRAME_4K) | (va64 & OFF_4K);
                        else if (commit)
                            words[w] = '0;
                    end
                end
            end
            if (st != ST_OK)
            begin
                r.value = '0;
                r.kind = KIND_4K;
            end
            r.status = st;
            return r;
        endfunction

        function void note_command(cmd_code_t cmd, logic [VA_W-1:0] va,
                                   logic [DATA_W-1:0] data);
            walk_result_t r;
            r = walk(cmd, va, data, 1'b1);
            pending_results.push_back(r);
            if (r.status == ST_RANGE)
                n_range++;
            else if (r.status == ST_ABSENT)
                n_absent++;
            else if (cmd == CMD_TRANSLATE)
            begin
                if (r.kind == KIND_1G)
                    n_1g++;
                else if (r.kind == KIND_2M)
                    n_2m++;
                else
                    n_4k++;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] value, logic [1:0] st,
                                   logic [1:0] kind);
            walk_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %h %0d %0d",
                         $time, value, st, kind);
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value)
            begin
                mismatches++;
                $display("%0t: result_value expected %h actual %h", $time, want.value, value);
            end
            if (st !== want.status)
            begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
            if (kind !== want.kind)
            begin
                mismatches++;
                $display("%0t: page_kind expected %0d actual %0d", $time, want.kind, kind);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        command = CMD_READ;
    logic [VA_W-1:0]   address = '0;
    logic [DATA_W-1:0] write_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] result_value;
    logic [1:0]        status;
    logic [1:0]        page_kind;
    logic              config_write = 1'b0;
    logic              config_index = REG_ROOT;
    logic [PA_W-1:0]   config_data = '0;

    ptw_mirror       book = new();
    logic [IDX_W-1:0] hot_idx [4][4];
    bit              quiet_in = 1'b0;
    bit              quiet_out = 1'b0;
    int              cycle_count = 0;
    int              n_items = 0;
    int              n_settings = 0;

    four_level_page_table_walker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status),
        .page_kind    (page_kind),
        .config_write (config_write),
        .config_index (config_index),
        .config_data  (config_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(result_value, status, page_kind);
    end

    // result side back-pressure
    initial
    begin
        int hold;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_out = !quiet_out;
            hold = quiet_out ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    task automatic send(cmd_code_t cmd, logic [VA_W-1:0] addr, logic [DATA_W-1:0] data);
        int gap;
        command <= cmd;
        address <= addr;
        write_data <= data;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        book.note_command(cmd, addr, data);
        n_items++;
        gap = quiet_in ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] table_entry();
        logic [63:0] frame;
        logic [11:0] flags;
        int          pick;
        pick = $urandom_range(0, 99);
        frame = {12'd0, book.base_reg} + 64'($urandom_range(0, TABLE_PAGES - 1)) * 64'd4096;
        if (pick < 6)
            frame = {$urandom, $urandom};
        flags = 12'($urandom);
        flags[ENTRY_LARGE_BIT] = ($urandom_range(0, 3) == 0);
        flags[ENTRY_PRESENT_BIT] = (pick >= 12);
        return {12'($urandom), frame[51:12], flags};
    endfunction

    // fill every unwritten word on the path first, one table level at a time
    task automatic issue(cmd_code_t cmd, logic [VA_W-1:0] addr, logic [DATA_W-1:0] data);
        logic [63:0] fill_addr;
        void'(book.walk(cmd, addr, data, 1'b0));
        while (book.gap_word >= 0)
        begin
            fill_addr = {12'd0, book.base_reg} + 64'(book.gap_word) * 64'd8;
            send(CMD_WRITE, fill_addr[VA_W-1:0], table_entry());
            void'(book.walk(cmd, addr, data, 1'b0));
        end
        send(cmd, addr, data);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_config(logic [PA_W-1:0] root, logic [PA_W-1:0] base);
        settle();
        config_write <= 1'b1;
        config_index <= REG_ROOT;
        config_data <= root;
        @(posedge clk);
        config_index <= REG_BASE;
        config_data <= base;
        @(posedge clk);
        config_write <= 1'b0;
        book.root_reg = root;
        book.base_reg = base;
        n_settings++;
        for (int l = 0; l < 4; l++)
        begin
            hot_idx[l][0] = '0;
            hot_idx[l][1] = '1;
            hot_idx[l][2] = IDX_W'($urandom);
            hot_idx[l][3] = IDX_W'($urandom);
        end
    endtask

    function automatic logic [VA_W-1:0] pick_va();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            return raw[VA_W-1:0];
        return {hot_idx[3][$urandom_range(0, 3)], hot_idx[2][$urandom_range(0, 3)],
                hot_idx[1][$urandom_range(0, 3)], hot_idx[0][$urandom_range(0, 3)], raw[11:0]};
    endfunction

    function automatic logic [VA_W-1:0] pick_word_addr();
        logic [63:0] a;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            a = {12'd0, book.base_reg} + 64'($urandom_range(0, STORE_SPAN - 1));
        else if (pick < 90)
            a = {12'd0, book.base_reg} - 64'($urandom_range(1, 8));
        else if (pick < 95)
            a = {12'd0, book.base_reg} + 64'(STORE_SPAN) + 64'($urandom_range(0, 7));
        else
            a = {$urandom, $urandom};
        return a[VA_W-1:0];
    endfunction

    task automatic run_random(int count);
        int                pick;
        logic [DATA_W-1:0] data;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_in = !quiet_in;
            pick = $urandom_range(0, 99);
            data = {$urandom, $urandom};
            if (pick < 45)
                issue(CMD_TRANSLATE, pick_va(), data);
            else if (pick < 55)
                issue(CMD_UNMAP, pick_va(), data);
            else if (pick < 75)
                issue(CMD_READ, pick_word_addr(), data);
            else
                issue(CMD_WRITE, pick_word_addr(),
                      ($urandom_range(0, 9) < 6) ? table_entry() : data);
        end
    endtask

    // tables at pages 1 to 4 of a store based at zero, root at page 1
    task automatic run_directed();
        issue(CMD_WRITE, 48'h0000_0000_1000, 64'hFFF0_0000_0000_2003);
        issue(CMD_WRITE, 48'h0000_0000_2000, 64'h0000_0000_0000_3003);
        issue(CMD_WRITE, 48'h0000_0000_3000, 64'h0000_0000_0000_4003);
        issue(CMD_WRITE, 48'h0000_0000_4000, 64'h8000_0000_1234_5003);
        issue(CMD_TRANSLATE, 48'h0000_0000_0ABC, '0);
        issue(CMD_WRITE, 48'h0000_0000_2008, 64'h8007_F000_4000_0083);
        issue(CMD_TRANSLATE, 48'h0000_7FFF_FFFF, '0);
        issue(CMD_WRITE, 48'h0000_0000_3008, 64'h000F_FFFF_FFE0_0083);
        issue(CMD_TRANSLATE, 48'h0000_003F_FFFF, '0);
        issue(CMD_WRITE, 48'h0000_0000_4008, 64'h7FFF_FFFF_FFFF_FFFE);
        issue(CMD_TRANSLATE, 48'h0000_0000_1FFF, '0);
        issue(CMD_WRITE, 48'h0000_0000_1FF8, 64'h000F_FFFF_FFFF_F001);
        issue(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0);
        issue(CMD_UNMAP, 48'h0000_4000_0000, '0);
        issue(CMD_UNMAP, 48'h0000_0000_0000, '0);
        issue(CMD_TRANSLATE, 48'h0000_0000_0000, '0);
        issue(CMD_UNMAP, 48'h0000_0000_0000, '0);
        issue(CMD_READ, 48'h0000_0000_4000, '0);
        issue(CMD_READ, 48'h0000_0000_1007, '0);
        issue(CMD_READ, 48'h0000_0001_0000, '0);
        issue(CMD_WRITE, 48'hFFFF_FFFF_FFFF, '1);
        issue(CMD_WRITE, 48'h0000_0000_FFF8, '1);
        issue(CMD_READ, 48'h0000_0000_FFFF, '0);
        issue(CMD_WRITE, 48'h0000_0000_1008, '0);
        issue(CMD_TRANSLATE, 48'h0080_0000_0000, '0);
    endtask

    initial
    begin
        logic [PA_W-1:0] odd_base;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(52'h0_0000_0000_1ABC, 52'h0);
        run_directed();
        run_random(300);

        set_config(52'h0_0000_8000_5123, 52'h0_0000_8000_0000);
        run_random(260);

        set_config(52'hF_FFFF_FFFF_FFFF & 52'h0_FFFF_FFFF_FFFF, 52'h0_FFFF_FFFF_0000);
        run_random(260);

        odd_base = {4'd0, 16'($urandom_range(0, 16'hFFFE)), 32'($urandom)};
        set_config(odd_base + 52'($urandom_range(0, TABLE_PAGES - 1)) * 52'd4096
                   + 52'($urandom_range(0, 4095)), odd_base);
        run_random(260);

        set_config(52'hF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF);
        run_random(120);

        set_config(52'h0, 52'h0);
        run_random(250);

        settle();
        $display("%0d commands over %0d register settings; translations: %0d 4KB, %0d 2MB, %0d 1GB",
                 n_items, n_settings, book.n_4k, book.n_2m, book.n_1g);
        $display("%0d not-present and %0d out-of-store outcomes seen, %0d mismatches",
                 book.n_absent, book.n_range, book.mismatches);
        if (book.mismatches == 0 && book.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
